/* src/assert_macros.svh */
// Assertion macros for the radix conversion block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define RC_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define RC_ASSERT(lbl, prop, msg)
`define RC_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

/* src/rc_pkg.sv */
// Types, constants and control program of the radix conversion block.
package rc_pkg;

	localparam int VALUE_W = 31;
	localparam int DIGIT_W = 4;
	localparam int RADIX_W = 5;
	localparam int BITCNT_W = $clog2(VALUE_W);
	localparam int MAX_DIGITS_DEF = 32;

	localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
	localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

	typedef logic [2:0] step_t;

	localparam step_t STEP_IDLE     = 3'd0;
	localparam step_t STEP_DIV_INIT = 3'd1;
	localparam step_t STEP_DIV      = 3'd2;
	localparam step_t STEP_PUSH     = 3'd3;
	localparam step_t STEP_POP      = 3'd4;
	localparam step_t STEP_LOAD     = 3'd5;
	localparam step_t STEP_WAIT     = 3'd6;
	localparam step_t STEP_MORE     = 3'd7;

	typedef enum logic [2:0] {
		JC_NEXT,
		JC_NO_INPUT,
		JC_DIV_BUSY,
		JC_NONZERO,
		JC_OUT_BUSY,
		JC_MORE
	} jump_t;

	typedef struct packed {
		logic  ld_in;
		logic  div_init;
		logic  div_step;
		logic  push;
		logic  pop;
		logic  load_out;
		jump_t cond;
		step_t target;
	} ctl_t;

	// Control store: a taken jump goes to target, otherwise to the next step.
	// The last step falls through to the idle step.
	function automatic ctl_t rom_word(step_t s);
		ctl_t w;
		w.ld_in = 1'b0;
		w.div_init = 1'b0;
		w.div_step = 1'b0;
		w.push = 1'b0;
		w.pop = 1'b0;
		w.load_out = 1'b0;
		w.cond = JC_NEXT;
		w.target = STEP_IDLE;
		case (s)
			STEP_IDLE: begin
				w.ld_in = 1'b1;
				w.cond = JC_NO_INPUT;
				w.target = STEP_IDLE;
			end
			STEP_DIV_INIT: begin
				w.div_init = 1'b1;
			end
			STEP_DIV: begin
				w.div_step = 1'b1;
				w.cond = JC_DIV_BUSY;
				w.target = STEP_DIV;
			end
			STEP_PUSH: begin
				w.push = 1'b1;
				w.cond = JC_NONZERO;
				w.target = STEP_DIV_INIT;
			end
			STEP_POP: begin
				w.pop = 1'b1;
			end
			STEP_LOAD: begin
				w.load_out = 1'b1;
			end
			STEP_WAIT: begin
				w.cond = JC_OUT_BUSY;
				w.target = STEP_WAIT;
			end
			STEP_MORE: begin
				w.cond = JC_MORE;
				w.target = STEP_POP;
			end
			default: begin
				w.cond = JC_NEXT;
			end
		endcase
		return w;
	endfunction

endpackage

/* src/radix_conversion_top.sv */
// Radix conversion top level: microcoded repeated division with a digit stack.
//
// Input channel (in_valid, in_stall, value): one 31-bit non-negative integer
// per transfer. in_stall is low only while the block is idle.
// Output channel (out_valid, out_stall, digit, last): one transfer per digit,
// most significant first; last marks the least significant digit. Zero gives
// a single digit 0.
// Configuration: cfg_wen writes cfg_wdata into the radix register (reset 10).
// Values below 2 act as 2, above 16 as 16.
// Sequence: each digit comes from one bit-serial restoring division loop,
// framed by the div-init and push steps; once all digits are stacked, each
// is popped, loaded into the output register and handed to the receiver.
// While out_stall is high the sequencer holds the digit and waits.
// Reset clears the sequencer, the stack count, the bit counter, the output
// valid and sets the radix to 10. The digit stack needs no clearing.
module radix_conversion_top #(
	parameter int MAX_DIGITS = rc_pkg::MAX_DIGITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wen,
	input  logic [rc_pkg::RADIX_W-1:0]  cfg_wdata,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [rc_pkg::VALUE_W-1:0]  value,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [rc_pkg::DIGIT_W-1:0]  digit,
	output logic                        last
);
	import rc_pkg::*;

	localparam int AW = $clog2(MAX_DIGITS);
	localparam int CW = $clog2(MAX_DIGITS + 1);

	step_t                pc_q, pc_d;
	ctl_t                 ctl;
	logic                 take;
	logic [RADIX_W-1:0]   radix_q, base;
	logic [VALUE_W-1:0]   n_q;
	logic [DIGIT_W-1:0]   rem_q;
	logic [BITCNT_W-1:0]  bitcnt_q;
	logic [CW-1:0]        count_q, count_dec;
	logic [RADIX_W-1:0]   trial, diff;
	logic                 ge;
	logic [DIGIT_W-1:0]   stack_mem [MAX_DIGITS];
	logic [DIGIT_W-1:0]   rd_q;
	logic                 out_valid_q, last_q;
	logic [DIGIT_W-1:0]   digit_q;

	assign ctl = rom_word(pc_q);
	assign in_stall = ~ctl.ld_in;
	assign out_valid = out_valid_q;
	assign digit = digit_q;
	assign last = last_q;

	always_comb begin
		if (radix_q < RADIX_MIN)
			base = RADIX_MIN;
		else if (radix_q > RADIX_MAX)
			base = RADIX_MAX;
		else
			base = radix_q;
	end

	assign trial = {rem_q, n_q[VALUE_W-1]};
	assign ge = (trial >= base);
	assign diff = trial - base;
	assign count_dec = count_q - CW'(1);

	always_comb begin
		case (ctl.cond)
			JC_NEXT:     take = 1'b0;
			JC_NO_INPUT: take = ~in_valid;
			JC_DIV_BUSY: take = (bitcnt_q != '0);
			JC_NONZERO:  take = (n_q != '0);
			JC_OUT_BUSY: take = out_valid_q;
			JC_MORE:     take = (count_q != '0);
			default:     take = 1'b0;
		endcase
		pc_d = take ? ctl.target : pc_q + 3'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= STEP_IDLE;
			radix_q <= RADIX_RESET;
			count_q <= '0;
			bitcnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			pc_q <= pc_d;
			if (cfg_wen)
				radix_q <= cfg_wdata;
			if (ctl.ld_in && in_valid)
				count_q <= '0;
			else if (ctl.push && (count_q < CW'(MAX_DIGITS)))
				count_q <= count_q + CW'(1);
			else if (ctl.pop)
				count_q <= count_dec;
			if (ctl.div_init)
				bitcnt_q <= BITCNT_W'(VALUE_W - 1);
			else if (ctl.div_step)
				bitcnt_q <= bitcnt_q - BITCNT_W'(1);
			if (ctl.load_out)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// Restoring division, one quotient bit per cycle; n_q ends as the quotient.
	always_ff @(posedge clk) begin
		if (ctl.ld_in && in_valid)
			n_q <= value;
		else if (ctl.div_step)
			n_q <= {n_q[VALUE_W-2:0], ge};
		if (ctl.div_init)
			rem_q <= '0;
		else if (ctl.div_step)
			rem_q <= ge ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (ctl.push && (count_q < CW'(MAX_DIGITS)))
			stack_mem[count_q[AW-1:0]] <= rem_q;
		if (ctl.pop)
			rd_q <= stack_mem[count_dec[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (ctl.load_out) begin
			digit_q <= rd_q;
			last_q <= (count_q == '0);
		end
	end

`include "assert_macros.svh"

	`RC_ASSERT(a_in_idle, (in_valid && !in_stall) |-> !out_valid_q && count_q == '0, "input taken while busy")
	`RC_ASSERT(a_count_bound, count_q <= CW'(MAX_DIGITS), "stack count beyond depth")
	`RC_ASSERT(a_rem_range, (pc_q == STEP_PUSH) |-> (rem_q < base), "remainder not below radix")
	`RC_ASSERT(a_out_step, out_valid_q |-> (pc_q == STEP_WAIT), "output valid outside wait step")

endmodule
